### design/iafold_pkg.sv
// Shared types, codes and the saturation helper for the interval fold block.
package iafold_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 64;

  localparam logic signed [PROD_W-1:0] WORD_MAX_EXT = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] WORD_MIN_EXT = -64'sh0000_0000_8000_0000;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ISSUE,
    ST_WAIT,
    ST_FOLD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              ovf;
    logic [WORD_W-1:0] val;
  } sat_t;

  // Clamp a wide signed value to the signed word range.
  function automatic sat_t sat_word(input logic signed [PROD_W-1:0] v);
    sat_t s;
    if (v > WORD_MAX_EXT) begin
      s.ovf = 1'b1;
      s.val = WORD_MAX_EXT[WORD_W-1:0];
    end else if (v < WORD_MIN_EXT) begin
      s.ovf = 1'b1;
      s.val = WORD_MIN_EXT[WORD_W-1:0];
    end else begin
      s.ovf = 1'b0;
      s.val = v[WORD_W-1:0];
    end
    return s;
  endfunction

endpackage

### design/interval_arithmetic_fold_core.sv
// Top level of the interval fold: sequencer, accumulator and the shared mul/div units.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | mode, arg_lower, arg_upper, first_arg, last_arg
//   out_    | output    | out_valid / out_ready | result_lower, result_upper, div_zero,
//           |           |                       | overflow, final_result
//
// First, add, subtract and zero-divisor beats go from idle through CALC straight to DONE.
// Multiply runs the four bound products through one multiplier, one after another.
// Divide runs four quotients through one bit-serial divider of 32+FRAC_BITS steps.
// One beat is in work at a time; in_ready is high only while idle. A finished result
// waits in the output register, and the next result waits until it has been taken.
// rst_n is synchronous; it clears the accumulator, both flags and the output valid.
module interval_arithmetic_fold_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic signed [iafold_pkg::WORD_W-1:0] in_arg_lower,
  input  logic signed [iafold_pkg::WORD_W-1:0] in_arg_upper,
  input  logic                                in_first_arg,
  input  logic                                in_last_arg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iafold_pkg::WORD_W-1:0] out_result_lower,
  output logic signed [iafold_pkg::WORD_W-1:0] out_result_upper,
  output logic                                out_div_zero,
  output logic                                out_overflow,
  output logic                                out_final_result
);

  localparam int QW = iafold_pkg::WORD_W + FRAC_BITS + 1;
  localparam int W  = iafold_pkg::WORD_W;
  localparam int PW = iafold_pkg::PROD_W;

  iafold_pkg::state_t state_r, state_nxt;

  iafold_pkg::mode_t   mode_r;
  logic signed [W-1:0] a_lo_r, a_hi_r;
  logic                first_r, last_r;

  logic signed [W-1:0] acc_lo_r, acc_hi_r;
  logic                dz_r, ovf_r;

  logic [1:0]          idx_r;
  logic signed [W-1:0] min_r, max_r;
  logic signed [W-1:0] cand_r;
  logic                cand_ovf_r;
  logic                fold_ovf_r;

  logic signed [W-1:0] out_lo_r, out_hi_r;
  logic                out_dz_r, out_ovf_r, out_last_r, out_valid_r;

  // Control from the output decoder.
  logic accept, calc_en, issue_en, cand_load, fold_en, done_load;

  logic is_mul, div_zero_arg;
  logic signed [W-1:0]  op_acc, op_arg;
  logic signed [PW-1:0] mul_p;
  logic                 div_done;
  logic signed [QW-1:0] div_q;
  logic signed [PW-1:0] cand_wide;
  iafold_pkg::sat_t     cand_sat;

  logic signed [W:0]    sum_lo, sum_hi;
  iafold_pkg::sat_t     sat_lo, sat_hi;

  logic signed [W-1:0]  lo_nxt, hi_nxt;
  logic                 fold_ovf_nxt;

  assign is_mul       = (mode_r == iafold_pkg::MODE_MUL);
  assign div_zero_arg = (a_lo_r == '0) || (a_hi_r == '0);

  // Candidates in order: upper*hi, upper*lo, lower*hi, lower*lo.
  assign op_acc = idx_r[1] ? acc_lo_r : acc_hi_r;
  assign op_arg = idx_r[0] ? a_lo_r : a_hi_r;

  iafold_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .en   (issue_en & is_mul),
    .op_a (op_acc),
    .op_b (op_arg),
    .prod (mul_p)
  );

  iafold_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (issue_en & ~is_mul),
    .num   (op_acc),
    .den   (op_arg),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cand_wide = is_mul ? mul_p : {{(PW-QW){div_q[QW-1]}}, div_q};
  assign cand_sat  = iafold_pkg::sat_word(cand_wide);

  always_comb begin
    if (mode_r == iafold_pkg::MODE_SUB) begin
      sum_lo = {acc_lo_r[W-1], acc_lo_r} - {a_hi_r[W-1], a_hi_r};
      sum_hi = {acc_hi_r[W-1], acc_hi_r} - {a_lo_r[W-1], a_lo_r};
    end else begin
      sum_lo = {acc_lo_r[W-1], acc_lo_r} + {a_lo_r[W-1], a_lo_r};
      sum_hi = {acc_hi_r[W-1], acc_hi_r} + {a_hi_r[W-1], a_hi_r};
    end
  end

  assign sat_lo = iafold_pkg::sat_word({{(PW-W-1){sum_lo[W]}}, sum_lo});
  assign sat_hi = iafold_pkg::sat_word({{(PW-W-1){sum_hi[W]}}, sum_hi});

  // Saturating each candidate first gives the same min, max and flag as the
  // model, since the clamp is monotonic.
  assign lo_nxt = ((idx_r == 2'd0) || (cand_r < min_r)) ? cand_r : min_r;
  assign hi_nxt = ((idx_r == 2'd0) || (cand_r > max_r)) ? cand_r : max_r;
  assign fold_ovf_nxt = ((idx_r == 2'd0) ? 1'b0 : fold_ovf_r) | cand_ovf_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iafold_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = iafold_pkg::ST_CALC;
      end
      iafold_pkg::ST_CALC: begin
        if (first_r || (mode_r == iafold_pkg::MODE_ADD) || (mode_r == iafold_pkg::MODE_SUB)
            || ((mode_r == iafold_pkg::MODE_DIV) && div_zero_arg)) begin
          state_nxt = iafold_pkg::ST_DONE;
        end else begin
          state_nxt = iafold_pkg::ST_ISSUE;
        end
      end
      iafold_pkg::ST_ISSUE: begin
        state_nxt = iafold_pkg::ST_WAIT;
      end
      iafold_pkg::ST_WAIT: begin
        if (is_mul || div_done) state_nxt = iafold_pkg::ST_FOLD;
      end
      iafold_pkg::ST_FOLD: begin
        state_nxt = (idx_r == 2'd3) ? iafold_pkg::ST_DONE : iafold_pkg::ST_ISSUE;
      end
      iafold_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = iafold_pkg::ST_IDLE;
      end
      default: state_nxt = iafold_pkg::ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready  = 1'b0;
    calc_en   = 1'b0;
    issue_en  = 1'b0;
    cand_load = 1'b0;
    fold_en   = 1'b0;
    done_load = 1'b0;
    case (state_r)
      iafold_pkg::ST_IDLE:  in_ready  = 1'b1;
      iafold_pkg::ST_CALC:  calc_en   = 1'b1;
      iafold_pkg::ST_ISSUE: issue_en  = 1'b1;
      iafold_pkg::ST_WAIT:  cand_load = is_mul | div_done;
      iafold_pkg::ST_FOLD:  fold_en   = 1'b1;
      iafold_pkg::ST_DONE:  done_load = ~out_valid_r | out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iafold_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Beat capture and fold scratch registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= iafold_pkg::mode_t'(in_mode);
      a_lo_r  <= in_arg_lower;
      a_hi_r  <= in_arg_upper;
      first_r <= in_first_arg;
      last_r  <= in_last_arg;
    end
    if (calc_en) begin
      idx_r <= 2'd0;
    end else if (fold_en) begin
      idx_r <= idx_r + 2'd1;
    end
    if (cand_load) begin
      cand_r     <= cand_sat.val;
      cand_ovf_r <= cand_sat.ovf;
    end
    if (fold_en) begin
      min_r      <= lo_nxt;
      max_r      <= hi_nxt;
      fold_ovf_r <= fold_ovf_nxt;
    end
    if (done_load) begin
      out_lo_r   <= acc_lo_r;
      out_hi_r   <= acc_hi_r;
      out_dz_r   <= dz_r;
      out_ovf_r  <= ovf_r;
      out_last_r <= last_r;
    end
  end

  // Accumulator and sticky flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_lo_r <= '0;
      acc_hi_r <= '0;
      dz_r     <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (calc_en) begin
      if (first_r) begin
        acc_lo_r <= a_lo_r;
        acc_hi_r <= a_hi_r;
        dz_r     <= 1'b0;
        ovf_r    <= 1'b0;
      end else if ((mode_r == iafold_pkg::MODE_ADD) || (mode_r == iafold_pkg::MODE_SUB)) begin
        acc_lo_r <= sat_lo.val;
        acc_hi_r <= sat_hi.val;
        ovf_r    <= ovf_r | sat_lo.ovf | sat_hi.ovf;
      end else if ((mode_r == iafold_pkg::MODE_DIV) && div_zero_arg) begin
        dz_r <= 1'b1;
      end
    end else if (fold_en && (idx_r == 2'd3)) begin
      acc_lo_r <= lo_nxt;
      acc_hi_r <= hi_nxt;
      ovf_r    <= ovf_r | fold_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_lower = out_lo_r;
  assign out_result_upper = out_hi_r;
  assign out_div_zero     = out_dz_r;
  assign out_overflow     = out_ovf_r;
  assign out_final_result = out_last_r;

  // The accumulator feeds the operand muxes and must hold while a unit works.
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iafold_pkg::ST_WAIT) |=> ($stable(acc_lo_r) && $stable(acc_hi_r)))
    else $error("accumulator changed while a candidate was in flight");

  // A multiply or divide fold always commits an ordered interval.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (fold_en && (idx_r == 2'd3)) |=> (acc_lo_r <= acc_hi_r))
    else $error("min/max fold committed lower above upper");

  // The divider reports back only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == iafold_pkg::ST_WAIT) && !is_mul))
    else $error("divider done outside of a divide wait");

  // A result is loaded only into a free or draining output register.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_lo_r) && $stable(out_hi_r)))
    else $error("pending result overwritten");

endmodule

### design/iafold_mul.sv
// Registered signed word multiplier with fixed-point rescale (floor).
module iafold_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [iafold_pkg::WORD_W-1:0] op_a,
  input  logic signed [iafold_pkg::WORD_W-1:0] op_b,
  output logic signed [iafold_pkg::PROD_W-1:0] prod
);

  logic signed [iafold_pkg::PROD_W-1:0] full_prod;
  logic signed [iafold_pkg::PROD_W-1:0] prod_r;

  assign full_prod = op_a * op_b;

  // Arithmetic shift gives the floor of the scaled product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full_prod >>> FRAC_BITS;
    end
  end

  assign prod = prod_r;

endmodule

### design/iafold_div.sv
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit a cycle.
module iafold_div #(
  parameter int FRAC_BITS = 16,
  localparam int NW = iafold_pkg::WORD_W + FRAC_BITS,
  localparam int QW = NW + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [iafold_pkg::WORD_W-1:0] num,
  input  logic signed [iafold_pkg::WORD_W-1:0] den,
  output logic                                done,
  output logic signed [QW-1:0]                quo
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]                    cnt_r;
  logic                             fix_r;
  logic                             done_r;
  logic                             neg_r;
  logic [iafold_pkg::WORD_W-1:0]    dvs_r;
  logic [iafold_pkg::WORD_W-1:0]    rem_r;
  logic [NW-1:0]                    nq_r;
  logic signed [QW-1:0]             quo_r;

  logic [iafold_pkg::WORD_W-1:0]    num_mag;
  logic [iafold_pkg::WORD_W-1:0]    den_mag;
  logic [iafold_pkg::WORD_W:0]      rem_sh;
  logic [iafold_pkg::WORD_W:0]      rem_dif;
  logic                             q_bit;
  logic [QW-1:0]                    q_ext;
  logic                             rem_nz;

  assign num_mag = num[iafold_pkg::WORD_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[iafold_pkg::WORD_W-1] ? (~den + 1'b1) : den;

  assign rem_sh  = {rem_r, nq_r[NW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});

  assign q_ext  = {1'b0, nq_r};
  assign rem_nz = (rem_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fix_r;
      fix_r  <= (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[iafold_pkg::WORD_W-1] ^ den[iafold_pkg::WORD_W-1];
      dvs_r <= den_mag;
      rem_r <= '0;
      nq_r  <= {num_mag, {FRAC_BITS{1'b0}}};
    end else if (cnt_r != '0) begin
      rem_r <= q_bit ? rem_dif[iafold_pkg::WORD_W-1:0] : rem_sh[iafold_pkg::WORD_W-1:0];
      nq_r  <= {nq_r[NW-2:0], q_bit};
    end
  end

  // With opposite signs the floor is -q, less one more when a remainder is left.
  always_ff @(posedge clk) begin
    if (fix_r) begin
      quo_r <= neg_r ? $signed(~q_ext + {{(QW-1){1'b0}}, ~rem_nz}) : $signed(q_ext);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### tb/tb_interval_arithmetic_fold_core.sv
// Self-checking testbench for interval_arithmetic_fold_core: directed and random folds.
module tb_interval_arithmetic_fold_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 16;
  localparam int RAND_ARGS   = 1500;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYC  = 300;

  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q1    = 32'sh0001_0000;

  typedef struct {
    iafold_pkg::mode_t  mode;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    bit                 first;
    bit                 last;
    bit                 drain;
  } arg_item_t;

  typedef struct {
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    bit                 dz;
    bit                 ovf;
    bit                 fin;
  } interval_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = 2'd0;
  logic signed [31:0] in_arg_lower = '0;
  logic signed [31:0] in_arg_upper = '0;
  logic        in_first_arg = 1'b0;
  logic        in_last_arg = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] out_result_lower;
  logic signed [31:0] out_result_upper;
  logic        out_div_zero;
  logic        out_overflow;
  logic        out_final_result;

  arg_item_t     pending_args_q[$];
  interval_res_t fold_expect_q[$];
  arg_item_t     cur_arg;

  // Predicted accumulator and sticky flags.
  logic signed [31:0] fold_lo, fold_hi;
  bit                 fold_dz, fold_ovf;

  int mismatch_cnt = 0;
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit quiet_phase;

  interval_arithmetic_fold_core #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_arg_lower     (in_arg_lower),
    .in_arg_upper     (in_arg_upper),
    .in_first_arg     (in_first_arg),
    .in_last_arg      (in_last_arg),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_lower (out_result_lower),
    .out_result_upper (out_result_upper),
    .out_div_zero     (out_div_zero),
    .out_overflow     (out_overflow),
    .out_final_result (out_final_result)
  );

  always #5 clk = ~clk;

  // Every fifth stretch of 150 beats runs with no idling on either side.
  assign quiet_phase = ((accepted_cnt / 150) % 5) == 4;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] clamp_word(input longint v);
    if (v > longint'(W_MAX)) begin
      fold_ovf = 1'b1;
      return W_MAX;
    end
    if (v < longint'(W_MIN)) begin
      fold_ovf = 1'b1;
      return W_MIN;
    end
    return v[31:0];
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  task automatic fold_arg(input arg_item_t a);
    longint al, ah, lo, hi, mn, mx;
    longint c[4];
    interval_res_t r;
    bit minmax;
    al = a.lower;
    ah = a.upper;
    minmax = 1'b0;
    if (a.first) begin
      fold_lo = a.lower;
      fold_hi = a.upper;
      fold_dz = 1'b0;
      fold_ovf = 1'b0;
    end else begin
      case (a.mode)
        iafold_pkg::MODE_ADD: begin
          lo = longint'(fold_lo) + al;
          hi = longint'(fold_hi) + ah;
          fold_lo = clamp_word(lo);
          fold_hi = clamp_word(hi);
        end
        iafold_pkg::MODE_SUB: begin
          lo = longint'(fold_lo) - ah;
          hi = longint'(fold_hi) - al;
          fold_lo = clamp_word(lo);
          fold_hi = clamp_word(hi);
        end
        iafold_pkg::MODE_MUL: begin
          // Arithmetic shift of the exact product is the floor of the scaled value.
          c[0] = (longint'(fold_hi) * ah) >>> FRAC_BITS;
          c[1] = (longint'(fold_hi) * al) >>> FRAC_BITS;
          c[2] = (longint'(fold_lo) * ah) >>> FRAC_BITS;
          c[3] = (longint'(fold_lo) * al) >>> FRAC_BITS;
          minmax = 1'b1;
        end
        default: begin
          if (al == 0 || ah == 0) begin
            fold_dz = 1'b1;
          end else begin
            c[0] = floor_quot(longint'(fold_hi) <<< FRAC_BITS, ah);
            c[1] = floor_quot(longint'(fold_hi) <<< FRAC_BITS, al);
            c[2] = floor_quot(longint'(fold_lo) <<< FRAC_BITS, ah);
            c[3] = floor_quot(longint'(fold_lo) <<< FRAC_BITS, al);
            minmax = 1'b1;
          end
        end
      endcase
      if (minmax) begin
        mn = c[0];
        mx = c[0];
        for (int k = 1; k < 4; k++) begin
          if (c[k] < mn) mn = c[k];
          if (c[k] > mx) mx = c[k];
        end
        fold_lo = clamp_word(mn);
        fold_hi = clamp_word(mx);
      end
    end
    r.lower = fold_lo;
    r.upper = fold_hi;
    r.dz = fold_dz;
    r.ovf = fold_ovf;
    r.fin = a.last;
    fold_expect_q.push_back(r);
  endtask

  task automatic add_item(input iafold_pkg::mode_t m, input logic signed [31:0] lo,
                          input logic signed [31:0] hi, input bit first, input bit last);
    arg_item_t a;
    a.mode = m;
    a.lower = lo;
    a.upper = hi;
    a.first = first;
    a.last = last;
    a.drain = 1'b0;
    pending_args_q.push_back(a);
  endtask

  function automatic logic signed [31:0] rand_bound(input iafold_pkg::mode_t m);
    int r;
    if (m == iafold_pkg::MODE_DIV && $urandom_range(0, 99) < 6) return '0;
    r = $urandom_range(0, 99);
    if (r < 45) return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    if (r < 65) return int'($urandom_range(0, 1 << 28)) - (1 << 27);
    if (r < 85) return $urandom;
    case ($urandom_range(0, 6))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return Q1;
      default: return -Q1;
    endcase
  endfunction

  // Driver: one beat at a time from the pending queue, random gaps between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      fold_lo = '0;
      fold_hi = '0;
      fold_dz = 1'b0;
      fold_ovf = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_arg(cur_arg);
        accepted_cnt++;
        send_gap = idle_len();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_args_q.size() != 0 &&
                     !(pending_args_q[0].drain && fold_expect_q.size() != 0)) begin
          cur_arg = pending_args_q.pop_front();
          in_mode <= cur_arg.mode;
          in_arg_lower <= cur_arg.lower;
          in_arg_upper <= cur_arg.upper;
          in_first_arg <= cur_arg.first;
          in_last_arg <= cur_arg.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction, stalls ready at random.
  always @(posedge clk) begin
    interval_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fold_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result beat: lower %h upper %h", out_result_lower,
                     out_result_upper);
        end else begin
          e = fold_expect_q.pop_front();
          if (out_result_lower !== e.lower || out_result_upper !== e.upper ||
              out_div_zero !== e.dz || out_overflow !== e.ovf ||
              out_final_result !== e.fin) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch (exp/act): lower %h/%h upper %h/%h dz %b/%b ovf %b/%b fin %b/%b",
                       e.lower, out_result_lower, e.upper, out_result_upper, e.dz,
                       out_div_zero, e.ovf, out_overflow, e.fin, out_final_result);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n, len, next_drain;
    iafold_pkg::mode_t m;
    logic signed [31:0] lo, hi, t;
    bit ordered;

    // Fold from the reset accumulator before any first argument.
    add_item(iafold_pkg::MODE_ADD, Q1, 2 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_SUB, W_MIN, W_MAX, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_ADD, -Q1, Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_SUB, W_MIN, W_MAX, 1'b0, 1'b1);
    // Ordinary expression, including zero divisor endpoints and a straddling divisor.
    add_item(iafold_pkg::MODE_MUL, Q1 + Q1 / 2, 2 * Q1 + Q1 / 2, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_SUB, Q1 / 2, Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_MUL, -2 * Q1, 3 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, '0, 2 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, -2 * Q1, '0, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, -Q1, 2 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, 2 * Q1, 4 * Q1, 1'b0, 1'b1);
    // Multiplying by an interval with a zero endpoint is an ordinary product.
    add_item(iafold_pkg::MODE_ADD, -3 * Q1, 5 * Q1, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_MUL, '0, 2 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_MUL, -Q1, '0, 1'b0, 1'b1);
    // Inverted intervals are used as given.
    add_item(iafold_pkg::MODE_DIV, 3 * Q1, -3 * Q1, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_ADD, 5 * Q1, -5 * Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_MUL, 2 * Q1, -Q1, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, -3 * Q1, 4 * Q1, 1'b0, 1'b1);
    // Saturating products and quotients.
    add_item(iafold_pkg::MODE_ADD, W_MAX, W_MAX, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_MUL, W_MAX, W_MAX, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, 32'sd1, 32'sd1, 1'b0, 1'b1);
    add_item(iafold_pkg::MODE_ADD, W_MIN, W_MIN, 1'b1, 1'b0);
    add_item(iafold_pkg::MODE_MUL, W_MIN, W_MIN, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_SUB, W_MIN, W_MAX, 1'b0, 1'b0);
    add_item(iafold_pkg::MODE_DIV, -32'sd1, -32'sd1, 1'b0, 1'b1);
    // A first argument in divide mode with zero bounds skips the zero check.
    add_item(iafold_pkg::MODE_DIV, '0, '0, 1'b1, 1'b1);
    add_item(iafold_pkg::MODE_MUL, '0, '0, 1'b0, 1'b1);

    n = 0;
    next_drain = RAND_ARGS / 3;
    while (n < RAND_ARGS) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          m = iafold_pkg::mode_t'($urandom_range(0, 3));
          lo = rand_bound(m);
          hi = rand_bound(m);
          ordered = $urandom_range(0, 99) < 75;
          if (ordered && lo > hi) begin
            t = lo;
            lo = hi;
            hi = t;
          end
          add_item(m, lo, hi, k == 0, k == len - 1);
          if (k == 0 && n >= next_drain) begin
            pending_args_q[$].drain = 1'b1;
            next_drain += RAND_ARGS / 3;
          end
        end
        n += len;
      end else begin
        m = iafold_pkg::mode_t'($urandom_range(0, 3));
        add_item(m, rand_bound(m), rand_bound(m), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_args_q.size() != 0 || in_valid || fold_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatch_cnt == 0 && fold_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### interval_arithmetic_fold_core.f
design/iafold_pkg.sv
design/iafold_mul.sv
design/iafold_div.sv
design/interval_arithmetic_fold_core.sv
tb/tb_interval_arithmetic_fold_core.sv
